[hw/rtl/tofrb_pkg.sv]
`default_nettype none
package tofrb_pkg;

   typedef struct packed {
      logic [15:0] data_word;
      logic [11:0] word_position;
      logic [11:0] block_length;
      logic [4:0]  node_id;
      logic        block_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  target_index;
      logic [20:0] value;
      logic [3:0]  status_code;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_ADC   = 3'd0,
      KIND_TDC   = 3'd1,
      KIND_FINE  = 3'd2,
      KIND_PAT   = 3'd3,
      KIND_WARN  = 3'd4,
      KIND_END   = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      WARN_MISMATCH = 4'd0,
      WARN_TYPE     = 4'd1,
      WARN_SLOT     = 4'd2,
      WARN_NOHEAD   = 4'd3,
      WARN_EARLY    = 4'd4,
      WARN_EVENT    = 4'd5,
      WARN_COUNT    = 4'd6,
      WARN_OVERFLOW = 4'd7,
      WARN_NODE     = 4'd8
   } warn_type;

   // classified work for the back end
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_NODE    = 3'd1,
      OP_MISM    = 3'd2,
      OP_ADC     = 3'd3,
      OP_PAT     = 3'd4,
      OP_PAIR    = 3'd5
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  index;
      logic [11:0] adc_value;
      logic [9:0]  pat_value;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic [4:0]  node_id;
      logic        block_end;
   } work_type;

   localparam logic [11:0] TDC_START = 12'd94;
   localparam logic [11:0] PAT_A     = 12'd91;
   localparam logic [11:0] PAT_B     = 12'd92;
   localparam logic [11:0] CNT_MAX   = 12'd4095;

   function automatic logic node_ok(input logic [4:0] n);
      return n == 5'd4 || n == 5'd6 || n == 5'd18 || n == 5'd20;
   endfunction

   function automatic logic [2:0] base_of(input logic [4:0] n, input logic grp);
      logic [1:0] plane;
      logic       side;
      if (n == 5'd4 || n == 5'd6) begin
         plane = {1'b0, grp};
         side  = (n == 5'd4) ? ~grp : grp;
      end else begin
         plane = 2'd3 - {1'b0, grp};
         side  = (n == 5'd18);
      end
      return {plane, side};
   endfunction

   function automatic logic [9:0] reorder(input logic [15:0] w);
      return {w[9], w[4], w[8], w[3], w[7], w[2], w[6], w[1], w[5], w[0]};
   endfunction

endpackage
`default_nettype wire

[hw/rtl/tofrb_front.sv]
`default_nettype none
module tofrb_front #(
   parameter int ADC_WORDS = 90
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tofrb_pkg::req_type  item,
   input  wire logic                take,
   output tofrb_pkg::work_type      work
);

   logic [15:0] held_ff, held_in;
   logic [11:0] pos, rel;
   logic [3:0]  id;
   logic [7:0]  grp;
   logic [3:0]  rem;
   logic [12:0] prod;
   logic [12:0] lim;
   logic [6:0]  ich;
   logic [2:0]  tgt;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_comb begin
      pos  = item.word_position;
      rel  = pos - tofrb_pkg::TDC_START;
      id   = item.data_word[15:12];
      // group of nine by reciprocal multiply, exact below 128
      prod = 13'(pos[6:0]) * 13'd57;
      grp  = {4'd0, prod[12:9]};
      rem  = 4'(pos[6:0] - 7'({grp[3:0], 3'd0} + {3'd0, grp[3:0]}));
      lim  = 13'(item.block_length) - 13'd105;
      ich  = 7'({grp[2:0], id[0]});
      tgt  = 3'd0;
      case (item.node_id)
         5'd4:    tgt = (pos == tofrb_pkg::PAT_A) ? 3'd0 : 3'd3;
         5'd6:    tgt = (pos == tofrb_pkg::PAT_A) ? 3'd1 : 3'd2;
         5'd18:   tgt = (pos == tofrb_pkg::PAT_A) ? 3'd4 : 3'd6;
         default: tgt = (pos == tofrb_pkg::PAT_A) ? 3'd5 : 3'd7;
      endcase
      held_in           = held_ff;
      work              = '0;
      work.op           = tofrb_pkg::OP_NONE;
      work.node_id      = item.node_id;
      work.block_end    = item.block_end;
      work.first_word   = held_ff;
      work.second_word  = item.data_word;
      work.adc_value    = item.data_word[11:0];
      work.pat_value    = tofrb_pkg::reorder(item.data_word);
      if (!tofrb_pkg::node_ok(item.node_id)) begin
         work.op = tofrb_pkg::OP_NODE;
      end else if (pos < 12'(ADC_WORDS)) begin
         if ({4'd0, rem} != {4'd0, id}) begin
            work.op    = tofrb_pkg::OP_MISM;
            work.index = pos[6:0];
         end else if (id < 4'd4 && grp < 8'd5) begin
            work.op    = tofrb_pkg::OP_ADC;
            work.index = 7'(tofrb_pkg::base_of(item.node_id, id[1])) * 7'd10 + ich;
         end
      end else if (pos == tofrb_pkg::PAT_A || pos == tofrb_pkg::PAT_B) begin
         work.op    = tofrb_pkg::OP_PAT;
         work.index = {4'd0, tgt};
      end else if (pos >= tofrb_pkg::TDC_START) begin
         if (!rel[0]) begin
            held_in = item.data_word;
         end else if ($signed({2'b0, rel} - 14'd1) < $signed({lim[12], lim})) begin
            work.op = tofrb_pkg::OP_PAIR;
         end
      end
      if (!take) begin
         held_in = held_ff;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/tofrb_queue.sv]
`default_nettype none
module tofrb_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tofrb_pkg::work_type  wr_data,
   input  wire logic                 wr_en,
   output logic                      full,
   output tofrb_pkg::work_type       rd_data,
   input  wire logic                 rd_en,
   output logic                      empty
);

   localparam int AW = $clog2(DEPTH);

   tofrb_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_comb begin
      full    = cnt_ff == (AW+1)'(DEPTH);
      empty   = cnt_ff == '0;
      rd_data = mem_ff[rp_ff];
      wp_in   = wr_en ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in   = rd_en ? ((rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in  = cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
   end

endmodule
`default_nettype wire

[hw/rtl/tofrb_back.sv]
`default_nettype none
module tofrb_back #(
   parameter int SLOT_DEPTH = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tofrb_pkg::work_type  work,
   input  wire logic                 work_valid,
   output logic                      work_take,
   output tofrb_pkg::rsp_type        rsp_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_pop
);

   // up to three results per item, sent from a small buffer
   tofrb_pkg::rsp_type buf_ff [3];
   tofrb_pkg::rsp_type buf_in [3];
   logic [1:0] n_ff, n_in, i_ff, i_in;

   logic [11:0] cnt_ff [5];
   logic [11:0] cnt_in [5];
   logic [23:0] pend_ff [4];
   logic [23:0] pend_in [4];
   logic [11:0] sev_ff [5];
   logic [11:0] sev_in [5];

   logic [3:0]  ty, id;
   logic [2:0]  sid;
   logic [23:0] e;
   logic [11:0] evt, cnt;
   logic [23:0] p;
   logic [3:0]  pich;
   logic [20:0] tch;
   logic [2:0]  base;
   logic [1:0]  k;
   logic        done, go;
   tofrb_pkg::rsp_type r [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         i_ff <= '0;
         for (int s = 0; s < 5; s++) begin
            cnt_ff[s] <= '0;
         end
      end else begin
         n_ff <= n_in;
         i_ff <= i_in;
         for (int s = 0; s < 5; s++) begin
            cnt_ff[s] <= cnt_in[s];
         end
      end
      for (int s = 0; s < 5; s++) begin
         sev_ff[s] <= sev_in[s];
      end
      for (int s = 0; s < 4; s++) begin
         pend_ff[s] <= pend_in[s];
      end
      for (int s = 0; s < 3; s++) begin
         buf_ff[s] <= buf_in[s];
      end
   end

   function automatic tofrb_pkg::rsp_type mk(input tofrb_pkg::kind_type kd,
                                             input logic [6:0] ix,
                                             input logic [20:0] v,
                                             input tofrb_pkg::warn_type c);
      tofrb_pkg::rsp_type o;
      o.kind = kd;
      o.target_index = ix;
      o.value = v;
      o.status_code = c;
      o.last = 1'b0;
      return o;
   endfunction

   always_comb begin
      ty   = work.first_word[15:12];
      id   = work.first_word[11:8];
      sid  = id[2:0];
      e    = {work.first_word[7:0], work.second_word};
      evt  = e[23:12];
      cnt  = (id < 4'd5) ? cnt_ff[sid] : '0;
      p    = pend_ff[sid[1:0]];
      pich = {p[23:21], id[0]};
      tch  = {p[18:0], p[20:19]};
      base = tofrb_pkg::base_of(work.node_id, id[1]);
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      sev_in = sev_ff;
      for (int s = 0; s < 3; s++) begin
         r[s] = mk(tofrb_pkg::KIND_WARN, '0, '0, tofrb_pkg::WARN_MISMATCH);
      end
      k = '0;

      done      = (i_ff == n_ff);
      go        = work_valid && (done || (n_ff != '0 && i_ff == n_ff - 2'd1 && rsp_pop));
      work_take = go;

      case (work.op)
         tofrb_pkg::OP_NODE: begin
            r[0] = mk(tofrb_pkg::KIND_WARN, '0, '0, tofrb_pkg::WARN_NODE);
            k = 2'd1;
         end
         tofrb_pkg::OP_MISM: begin
            r[0] = mk(tofrb_pkg::KIND_WARN, work.index, '0, tofrb_pkg::WARN_MISMATCH);
            k = 2'd1;
         end
         tofrb_pkg::OP_ADC: begin
            r[0] = mk(tofrb_pkg::KIND_ADC, work.index, 21'(work.adc_value),
                      tofrb_pkg::WARN_MISMATCH);
            k = 2'd1;
         end
         tofrb_pkg::OP_PAT: begin
            r[0] = mk(tofrb_pkg::KIND_PAT, work.index, 21'(work.pat_value),
                      tofrb_pkg::WARN_MISMATCH);
            k = 2'd1;
         end
         tofrb_pkg::OP_PAIR: begin
            k = 2'd1;
            if (!(ty == 4'd8 || ty == 4'd2 || ty == 4'd4 || ty == 4'd3)) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_TYPE);
            end else if (id >= 4'd5) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_SLOT);
            end else if (cnt == '0 && ty != 4'd8) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_NOHEAD);
            end else if (cnt < 12'd2 && ty == 4'd3) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_EARLY);
            end else if (ty == 4'd3 && sev_ff[sid] != evt) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_EVENT);
            end else if (ty == 4'd3 && e[11:0] != cnt) begin
               r[0] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_COUNT);
            end else begin
               k = '0;
               if (id < 4'd4 && cnt >= 12'd3 && 13'(cnt) - 13'd1 < 13'(SLOT_DEPTH)) begin
                  if (pich < 4'd10) begin
                     r[k] = mk(tofrb_pkg::KIND_TDC,
                               7'(base) * 7'd10 + 7'(pich), tch, tofrb_pkg::WARN_MISMATCH);
                     k = k + 2'd1;
                  end else if (pich < 4'd12) begin
                     r[k] = mk(tofrb_pkg::KIND_FINE,
                               7'({base, 1'b0}) + 7'(pich - 4'd10), tch,
                               tofrb_pkg::WARN_MISMATCH);
                     k = k + 2'd1;
                  end
               end
               if (13'(cnt) >= 13'(SLOT_DEPTH)) begin
                  r[k] = mk(tofrb_pkg::KIND_WARN, {3'd0, id}, '0, tofrb_pkg::WARN_OVERFLOW);
                  k = k + 2'd1;
               end else if (go) begin
                  if (id < 4'd4) begin
                     pend_in[sid[1:0]] = e;
                  end
                  if (cnt == 12'd1) begin
                     sev_in[sid] = evt;
                  end
               end
               if (go && cnt != tofrb_pkg::CNT_MAX) begin
                  cnt_in[sid] = cnt + 12'd1;
               end
            end
         end
         default: k = '0;
      endcase

      if (work.block_end) begin
         r[k] = mk(tofrb_pkg::KIND_END, '0, '0, tofrb_pkg::WARN_MISMATCH);
         k = k + 2'd1;
         if (go) begin
            for (int s = 0; s < 5; s++) begin
               cnt_in[s] = '0;
            end
         end
      end
      if (k != '0) begin
         r[k - 2'd1].last = 1'b1;
      end

      rsp_valid = !done;
      rsp_data  = buf_ff[i_ff];
      buf_in    = buf_ff;
      n_in      = n_ff;
      i_in      = (rsp_valid && rsp_pop) ? i_ff + 2'd1 : i_ff;
      if (go) begin
         buf_in = r;
         n_in   = k;
         i_in   = '0;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/tof_readout_block_decoder.sv]
`default_nettype none
// channel   ports                      direction
// req       push / full / req_item     in, one word item
// rsp       pop / empty / rsp_item     out, one result item
//
// a word is taken each cycle while the four-entry work queue has room
// a taken word is written to the work queue; its results are then registered in the result buffer
// each word yields up to three items; one per cycle on the result side while pop is held
// slot counts and held word clear on synchronous reset
// result stalls back up the queue and then raise full
module tof_readout_block_decoder #(
   parameter int SLOT_DEPTH = 100,
   parameter int ADC_WORDS  = 90
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire tofrb_pkg::req_type  req_item,
   output logic                     empty,
   input  wire logic                pop,
   output tofrb_pkg::rsp_type       rsp_item
);

   tofrb_pkg::work_type w_in, w_out;
   logic q_full, q_empty, take, rsp_valid, acc;

   assign acc   = push && !q_full;
   assign full  = q_full;
   assign empty = !rsp_valid;

   tofrb_front #(.ADC_WORDS(ADC_WORDS)) u_front (
      .clock(clock), .reset(reset), .item(req_item), .take(acc), .work(w_in)
   );

   tofrb_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset), .wr_data(w_in), .wr_en(acc), .full(q_full),
      .rd_data(w_out), .rd_en(take), .empty(q_empty)
   );

   tofrb_back #(.SLOT_DEPTH(SLOT_DEPTH)) u_back (
      .clock(clock), .reset(reset), .work(w_out), .work_valid(!q_empty),
      .work_take(take), .rsp_data(rsp_item), .rsp_valid(rsp_valid), .rsp_pop(pop)
   );

endmodule
`default_nettype wire

[tb/tofrb_scoreboard.sv]
`default_nettype none
module tofrb_scoreboard (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic               full,
   input  wire tofrb_pkg::req_type req_item,
   input  wire logic               empty,
   input  wire logic               pop,
   input  wire tofrb_pkg::rsp_type rsp_item,
   output int                      errors,
   output int                      waiting
);

   localparam int SLOT_DEPTH = 100;
   localparam int ADC_WORDS  = 90;

   logic [15:0]        held_word;
   logic [11:0]        slot_count [5];
   logic [23:0]        slot_pending [4];
   logic [11:0]        slot_event [5];
   tofrb_pkg::rsp_type expected_q [$];

   function automatic logic [2:0] channel_base(logic [4:0] node, logic grp);
      logic [1:0] plane;
      logic       side;
      if (node == 5'd4 || node == 5'd6) begin
         plane = {1'b0, grp};
         side  = (node == 5'd4) ? !grp : grp;
      end else begin
         plane = 2'd3 - {1'b0, grp};
         side  = (node == 5'd18);
      end
      return {plane, side};
   endfunction

   function automatic logic [9:0] pattern_bits(logic [15:0] w);
      logic [9:0] r;
      r = '0;
      for (int b = 0; b < 5; b++) begin
         r[2 * b]     = w[b];
         r[2 * b + 1] = w[b + 5];
      end
      return r;
   endfunction

   task automatic emit(tofrb_pkg::kind_type k, int idx, logic [20:0] val, logic [3:0] code);
      tofrb_pkg::rsp_type r;
      r.kind         = k;
      r.target_index = idx[6:0];
      r.value        = val;
      r.status_code  = code;
      r.last         = 1'b0;
      expected_q.push_back(r);
   endtask

   task automatic decode_pair(logic [15:0] w, logic [4:0] node);
      logic [23:0] e;
      logic [3:0]  ty;
      logic [3:0]  id;
      logic [11:0] evt;
      logic [11:0] cnt;
      logic [23:0] p;
      int          ich;
      int          base;
      logic [20:0] tch;
      e   = {held_word[7:0], w};
      ty  = held_word[15:12];
      id  = held_word[11:8];
      evt = e[23:12];
      if (ty != 4'd8 && ty != 4'd2 && ty != 4'd4 && ty != 4'd3) begin
         emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_TYPE);
         return;
      end
      if (id >= 5) begin
         emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_SLOT);
         return;
      end
      cnt = slot_count[id];
      if (cnt == 0 && ty != 4'd8) begin
         emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_NOHEAD);
         return;
      end
      if (cnt < 2 && ty == 4'd3) begin
         emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_EARLY);
         return;
      end
      if (ty == 4'd3) begin
         if (slot_event[id] != evt) begin
            emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_EVENT);
            return;
         end
         if (e[11:0] != cnt) begin
            emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_COUNT);
            return;
         end
      end
      if (id < 4 && cnt >= 3 && cnt - 1 < SLOT_DEPTH) begin
         p    = slot_pending[id];
         ich  = p[23:21] * 2 + id[0];
         tch  = {p[18:0], p[20:19]};
         base = channel_base(node, id[1]);
         if (ich < 10) emit(tofrb_pkg::KIND_TDC, base * 10 + ich, tch, 0);
         else if (ich < 12) emit(tofrb_pkg::KIND_FINE, base * 2 + ich - 10, tch, 0);
      end
      if (cnt >= SLOT_DEPTH) begin
         emit(tofrb_pkg::KIND_WARN, id, 0, tofrb_pkg::WARN_OVERFLOW);
      end else begin
         if (id < 4) slot_pending[id] = e;
         if (cnt == 1) slot_event[id] = evt;
      end
      if (cnt < 12'd4095) slot_count[id] = cnt + 1;
   endtask

   task automatic decode_word(tofrb_pkg::req_type r);
      int          before_n;
      int          pos;
      int          rel;
      int          t;
      logic [3:0]  id;
      before_n = expected_q.size();
      pos      = r.word_position;
      if (!(r.node_id == 5'd4 || r.node_id == 5'd6 || r.node_id == 5'd18
            || r.node_id == 5'd20)) begin
         emit(tofrb_pkg::KIND_WARN, 0, 0, tofrb_pkg::WARN_NODE);
      end else if (pos < ADC_WORDS) begin
         id = r.data_word[15:12];
         if (pos % 9 != id) begin
            emit(tofrb_pkg::KIND_WARN, pos, 0, tofrb_pkg::WARN_MISMATCH);
         end else if (id < 4 && pos / 9 < 5) begin
            emit(tofrb_pkg::KIND_ADC,
                 channel_base(r.node_id, id[1]) * 10 + (pos / 9) * 2 + id[0],
                 {9'd0, r.data_word[11:0]}, 0);
         end
      end else if (pos == 91 || pos == 92) begin
         case (r.node_id)
            5'd4:    t = (pos == 91) ? 0 : 3;
            5'd6:    t = (pos == 91) ? 1 : 2;
            5'd18:   t = (pos == 91) ? 4 : 6;
            default: t = (pos == 91) ? 5 : 7;
         endcase
         emit(tofrb_pkg::KIND_PAT, t, {11'd0, pattern_bits(r.data_word)}, 0);
      end else if (pos >= 94) begin
         rel = pos - 94;
         if (rel % 2 == 0) held_word = r.data_word;
         else if (rel - 1 < int'(r.block_length) - 105) decode_pair(r.data_word, r.node_id);
      end
      if (r.block_end) begin
         for (int i = 0; i < 5; i++) slot_count[i] = '0;
         emit(tofrb_pkg::KIND_END, 0, 0, 0);
      end
      if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
   endtask

   always @(posedge clock) begin
      tofrb_pkg::rsp_type x;
      if (reset) begin
         held_word = '0;
         for (int i = 0; i < 5; i++) begin
            slot_count[i] = '0;
            slot_event[i] = '0;
         end
         for (int i = 0; i < 4; i++) slot_pending[i] = '0;
         expected_q.delete();
         errors = 0;
      end else begin
         if (push && !full) decode_word(req_item);
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               $error("unexpected item kind %0d", rsp_item.kind);
               errors++;
            end else begin
               x = expected_q.pop_front();
               if (rsp_item.kind !== x.kind) begin
                  $error("kind exp %0d got %0d", x.kind, rsp_item.kind);
                  errors++;
               end
               if (rsp_item.target_index !== x.target_index) begin
                  $error("target_index exp %0d got %0d", x.target_index,
                         rsp_item.target_index);
                  errors++;
               end
               if (rsp_item.value !== x.value) begin
                  $error("value exp %0h got %0h", x.value, rsp_item.value);
                  errors++;
               end
               if (rsp_item.status_code !== x.status_code) begin
                  $error("status_code exp %0d got %0d", x.status_code,
                         rsp_item.status_code);
                  errors++;
               end
               if (rsp_item.last !== x.last) begin
                  $error("last exp %0d got %0d", x.last, rsp_item.last);
                  errors++;
               end
            end
         end
      end
      waiting = expected_q.size();
   end

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   tofrb_pkg::req_type req_item;
   logic               empty;
   logic               pop;
   tofrb_pkg::rsp_type rsp_item;
   int                 errors;
   int                 waiting;
   bit                 calm;
   int                 sent;
   tofrb_pkg::req_type word_q [$];
   int                 tdc_pos;
   logic [11:0]        gen_count [5];
   logic [11:0]        gen_event [5];

   tof_readout_block_decoder uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item)
   );

   tofrb_scoreboard checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item), .errors(errors), .waiting(waiting)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = !clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[tof_readout_block_decoder] ERROR");
      $finish;
   end

   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         pop = calm || ($urandom_range(99) >= 11);
      end
   end

   // full only moves at rising edges, so its value at the falling edge holds for the next one
   task automatic send(tofrb_pkg::req_type r);
      if (!calm && $urandom_range(99) < 11) begin
         push = 1'b0;
         @(negedge clock);
      end
      push     = 1'b1;
      req_item = r;
      while (full) @(negedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic add_word(logic [15:0] d, int pos, logic [11:0] len, logic [4:0] node);
      tofrb_pkg::req_type r;
      r.data_word     = d;
      r.word_position = pos[11:0];
      r.block_length  = len;
      r.node_id       = node;
      r.block_end     = 1'b0;
      word_q.push_back(r);
   endtask

   task automatic flush_block(bit closed);
      if (closed && word_q.size() > 0) word_q[$].block_end = 1'b1;
      while (word_q.size() > 0) send(word_q.pop_front());
      push = 1'b0;
   endtask

   task automatic add_pair(logic [15:0] h, logic [15:0] w, logic [11:0] len,
                           logic [4:0] node);
      logic [3:0] id;
      id = h[11:8];
      add_word(h, tdc_pos, len, node);
      add_word(w, tdc_pos + 1, len, node);
      tdc_pos += 2;
      if (id < 5) begin
         if (gen_count[id] == 1) gen_event[id] = {h[7:0], w[15:12]};
         gen_count[id]++;
      end
   endtask

   // header, body entries and trailer for one slot, with optional corruption
   task automatic add_slot(logic [3:0] id, int body, logic [11:0] len, logic [4:0] node,
                           int spoil);
      logic [15:0] h;
      logic [15:0] w;
      for (int i = 0; i < body + 2; i++) begin
         h = {4'd8, id, 8'($urandom)};
         w = 16'($urandom);
         if (i > 0) h[15:12] = $urandom_range(1) ? 4'd2 : 4'd4;
         if (i == body + 1 && id < 5) begin
            h = {4'd3, id, gen_event[id][11:4]};
            w = {gen_event[id][3:0], gen_count[id]};
         end
         if ($urandom_range(99) < spoil) h = 16'($urandom);
         if ($urandom_range(99) < spoil) w = 16'($urandom);
         add_pair(h, w, len, node);
      end
   endtask

   task automatic gen_block(int overflow);
      logic [4:0]  node;
      logic [11:0] len;
      logic [3:0]  id;
      logic [15:0] d;
      int          pick;
      pick = $urandom_range(3);
      node = (pick == 0) ? 5'd4 : (pick == 1) ? 5'd6 : (pick == 2) ? 5'd18 : 5'd20;
      if ($urandom_range(99) < 6) node = 5'($urandom);
      len = ($urandom_range(99) < 80) ? 12'd4095 : 12'(105 + 2 * $urandom_range(12));
      if ($urandom_range(99) < 5) len = 12'($urandom);
      for (int i = 0; i < 5; i++) gen_count[i] = '0;
      for (int p = 0; p < 90; p++) begin
         if ($urandom_range(99) < 12) begin
            d = {4'(p % 9), 12'($urandom)};
            if ($urandom_range(99) < 10) d[15:12] = 4'($urandom);
            add_word(d, p, len, node);
         end
      end
      for (int p = 90; p < 94; p++)
         if ($urandom_range(99) < ((p == 91 || p == 92) ? 70 : 10))
            add_word(16'($urandom), p, len, node);
      tdc_pos = 94;
      if (overflow > 0) begin
         add_slot(4'($urandom_range(3)), overflow, len, node, 0);
      end else begin
         repeat ($urandom_range(1, 3)) begin
            id = ($urandom_range(99) < 92) ? 4'($urandom_range(4)) : 4'($urandom);
            add_slot(id, $urandom_range(4), len, node, 6);
         end
      end
      flush_block($urandom_range(99) < 90);
   endtask

   initial begin
      tofrb_pkg::req_type r;
      reset    = 1'b1;
      push     = 1'b0;
      calm     = 1'b0;
      sent     = 0;
      req_item = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: bad nodes, adc extremes, patterns, unused positions, tdc checks
      for (int i = 0; i < 5; i++) gen_count[i] = '0;
      add_word(16'hffff, 4095, 12'd0, 5'd0);
      add_word(16'h0000, 0, 12'd4095, 5'd31);
      add_word(16'h0fff, 0, 12'd4095, 5'd4);
      add_word(16'h1000, 10, 12'd4095, 5'd6);
      add_word(16'h8abc, 89, 12'd4095, 5'd18);
      add_word(16'h0123, 45, 12'd4095, 5'd20);
      add_word(16'h7fff, 3, 12'd4095, 5'd4);
      add_word(16'hffff, 91, 12'd4095, 5'd18);
      add_word(16'h02aa, 92, 12'd4095, 5'd20);
      add_word(16'hffff, 90, 12'd4095, 5'd4);
      add_word(16'hffff, 93, 12'd4095, 5'd4);
      tdc_pos = 94;
      add_pair(16'h2200, 16'h0000, 12'd4095, 5'd4);
      add_pair(16'h3100, 16'h0000, 12'd4095, 5'd4);
      add_slot(4'd0, 2, 12'd4095, 5'd4, 0);
      add_pair(16'h5000, 16'hffff, 12'd4095, 5'd4);
      add_pair(16'h8f00, 16'h0000, 12'd4095, 5'd4);
      add_pair(16'h3000, 16'h0000, 12'd4095, 5'd4);
      add_pair(16'h3000, 16'h0001, 12'd4095, 5'd4);
      add_slot(4'd3, 1, 12'd4095, 5'd4, 0);
      flush_block(1'b1);
      while (waiting != 0) @(negedge clock);

      // the overflow block at the end adds about two hundred more words
      while (sent < 100) begin
         if (sent > 40 && sent < 90) calm = 1'b1;
         else calm = 1'b0;
         if ($urandom_range(99) < 15) begin
            repeat (5) begin
               r = tofrb_pkg::req_type'(46'({$urandom, $urandom}));
               r.block_end = ($urandom_range(7) == 0);
               send(r);
            end
            push = 1'b0;
         end else begin
            gen_block(0);
         end
      end
      calm = 1'b0;
      gen_block(101);

      while (waiting != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("[tof_readout_block_decoder] OK");
      end else begin
         $display("[tof_readout_block_decoder] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/tofrb_pkg.sv
hw/rtl/tofrb_front.sv
hw/rtl/tofrb_queue.sv
hw/rtl/tofrb_back.sv
hw/rtl/tof_readout_block_decoder.sv
tb/tofrb_scoreboard.sv
tb/tb.sv
